// File: rtl/fdsc_pkg.sv
package fdsc_pkg;

    localparam int NUM_DETENTS = 5;
    localparam int ANGLE_W     = 16;
    localparam int STEP_W      = 13;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int WIDE_W      = ANGLE_W + 1;
    localparam int PROD_W      = 2 * WIDE_W;
    localparam int DIV_BITS    = PROD_W - 1;
    localparam int COUNT_W     = $clog2(DIV_BITS);
    localparam int SUM_W       = DIV_BITS + 2;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    localparam logic [STEP_W-1:0] STEP_RESET     = STEP_W'(256);
    localparam angle_t            CTL_LOW_RESET  = 16'sd0;
    localparam angle_t            CTL_HIGH_RESET = 16'sd32767;
    localparam angle_t            DETENT_RESET   = 16'sd0;
    localparam angle_t            ANGLE_MAX      = 16'sd32767;
    localparam angle_t            ANGLE_MIN      = -16'sd32768;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_UP   = 2'd1,
        CMD_DOWN = 2'd2,
        CMD_SET  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_STEP     = 3'd0,
        REG_CTL_LOW  = 3'd1,
        REG_CTL_HIGH = 3'd2,
        REG_DET0     = 3'd3,
        REG_DET1     = 3'd4,
        REG_DET2     = 3'd5,
        REG_DET3     = 3'd6,
        REG_DET4     = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t   cmd;
        angle_t angle;
    } in_word_t;

    typedef struct packed {
        angle_t target_angle;
        angle_t current_angle;
        angle_t control_value;
        logic   moving;
    } out_word_t;

    typedef struct packed {
        logic [STEP_W-1:0]             step;
        angle_t                        ctl_low;
        angle_t                        ctl_high;
        angle_t [NUM_DETENTS-1:0]      detent;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic mul;
        logic load;
        logic div;
        logic load_out;
    } dp_cmd_t;

endpackage

// File: rtl/fdsc_regs.sv
module fdsc_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [fdsc_pkg::DATA_W-1:0]  pwdata,
    output logic [fdsc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output fdsc_pkg::cfg_t               cfg
);

    fdsc_pkg::cfg_t     cfg_reg;
    fdsc_pkg::cfg_t     cfg_next;
    fdsc_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = fdsc_pkg::reg_idx_t'(paddr[fdsc_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                fdsc_pkg::REG_STEP:     cfg_next.step      = pwdata[fdsc_pkg::STEP_W-1:0];
                fdsc_pkg::REG_CTL_LOW:  cfg_next.ctl_low   = pwdata[fdsc_pkg::ANGLE_W-1:0];
                fdsc_pkg::REG_CTL_HIGH: cfg_next.ctl_high  = pwdata[fdsc_pkg::ANGLE_W-1:0];
                fdsc_pkg::REG_DET0:     cfg_next.detent[0] = pwdata[fdsc_pkg::ANGLE_W-1:0];
                fdsc_pkg::REG_DET1:     cfg_next.detent[1] = pwdata[fdsc_pkg::ANGLE_W-1:0];
                fdsc_pkg::REG_DET2:     cfg_next.detent[2] = pwdata[fdsc_pkg::ANGLE_W-1:0];
                fdsc_pkg::REG_DET3:     cfg_next.detent[3] = pwdata[fdsc_pkg::ANGLE_W-1:0];
                fdsc_pkg::REG_DET4:     cfg_next.detent[4] = pwdata[fdsc_pkg::ANGLE_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            fdsc_pkg::REG_STEP:
                prdata = {{(fdsc_pkg::DATA_W-fdsc_pkg::STEP_W){1'b0}}, cfg_reg.step};
            fdsc_pkg::REG_CTL_LOW:
                prdata = fdsc_pkg::DATA_W'(cfg_reg.ctl_low);
            fdsc_pkg::REG_CTL_HIGH:
                prdata = fdsc_pkg::DATA_W'(cfg_reg.ctl_high);
            fdsc_pkg::REG_DET0:
                prdata = fdsc_pkg::DATA_W'(fdsc_pkg::angle_t'(cfg_reg.detent[0]));
            fdsc_pkg::REG_DET1:
                prdata = fdsc_pkg::DATA_W'(fdsc_pkg::angle_t'(cfg_reg.detent[1]));
            fdsc_pkg::REG_DET2:
                prdata = fdsc_pkg::DATA_W'(fdsc_pkg::angle_t'(cfg_reg.detent[2]));
            fdsc_pkg::REG_DET3:
                prdata = fdsc_pkg::DATA_W'(fdsc_pkg::angle_t'(cfg_reg.detent[3]));
            fdsc_pkg::REG_DET4:
                prdata = fdsc_pkg::DATA_W'(fdsc_pkg::angle_t'(cfg_reg.detent[4]));
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step     <= fdsc_pkg::STEP_RESET;
            cfg_reg.ctl_low  <= fdsc_pkg::CTL_LOW_RESET;
            cfg_reg.ctl_high <= fdsc_pkg::CTL_HIGH_RESET;
            cfg_reg.detent   <= {fdsc_pkg::NUM_DETENTS{fdsc_pkg::DETENT_RESET}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/fdsc_ctrl.sv
module fdsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output fdsc_pkg::dp_cmd_t dp_cmd
);

    fdsc_pkg::state_t             state_reg;
    fdsc_pkg::state_t             state_next;
    logic [fdsc_pkg::COUNT_W-1:0] count_reg;
    logic [fdsc_pkg::COUNT_W-1:0] count_next;
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;

    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        dp_cmd         = '0;
        case (state_reg)
            fdsc_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    dp_cmd.accept = 1'b1;
                    state_next    = fdsc_pkg::ST_MUL;
                end
            end
            fdsc_pkg::ST_MUL:
            begin
                dp_cmd.mul = 1'b1;
                state_next = fdsc_pkg::ST_ABS;
            end
            fdsc_pkg::ST_ABS:
            begin
                dp_cmd.load = 1'b1;
                count_next  = '0;
                state_next  = fdsc_pkg::ST_DIV;
            end
            fdsc_pkg::ST_DIV:
            begin
                dp_cmd.div = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == fdsc_pkg::COUNT_W'(fdsc_pkg::DIV_BITS - 1))
                begin
                    state_next = fdsc_pkg::ST_DONE;
                end
            end
            fdsc_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    dp_cmd.load_out = 1'b1;
                    rsp_valid_next  = 1'b1;
                    state_next      = fdsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fdsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fdsc_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// File: rtl/fdsc_dp.sv
module fdsc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  fdsc_pkg::cfg_t      cfg,
    input  fdsc_pkg::in_word_t  req_data,
    input  fdsc_pkg::dp_cmd_t   dp_cmd,
    output fdsc_pkg::out_word_t rsp_data
);

    localparam int AW = fdsc_pkg::ANGLE_W;
    localparam int WW = fdsc_pkg::WIDE_W;
    localparam int PW = fdsc_pkg::PROD_W;
    localparam int DB = fdsc_pkg::DIV_BITS;
    localparam int SW = fdsc_pkg::SUM_W;

    fdsc_pkg::angle_t req_reg, req_next;
    fdsc_pkg::angle_t target_reg, target_next;
    fdsc_pkg::angle_t pos_reg, pos_next;
    logic             slewing_reg, slewing_next;

    logic signed [PW-1:0] prod_reg;
    logic signed [WW-1:0] range_reg;
    logic                 neg_reg;
    logic                 zero_reg;
    logic [AW-1:0]        dvs_reg;
    logic [DB-1:0]        quo_reg;
    logic [AW-1:0]        rem_reg;
    fdsc_pkg::out_word_t  out_reg;

    fdsc_pkg::angle_t det [fdsc_pkg::NUM_DETENTS];
    fdsc_pkg::angle_t d_lo;
    fdsc_pkg::angle_t d_hi;
    fdsc_pkg::angle_t up_val;
    fdsc_pkg::angle_t dn_val;
    fdsc_pkg::angle_t new_req;
    logic [AW-1:0]        step_ext;
    logic signed [WW-1:0] diff;
    logic [WW-1:0]        mag;

    logic signed [WW-1:0] pos_off;
    logic signed [WW-1:0] span;
    logic signed [WW-1:0] range_w;
    logic signed [PW-1:0] prod_w;
    logic [WW-1:0]        rng_mag;
    logic [PW-1:0]        prod_mag;
    logic [AW:0]          trial;
    logic                 q_bit;
    logic [AW-1:0]        rem_w;
    logic signed [SW-1:0] q_signed;
    logic signed [SW-1:0] sum;
    fdsc_pkg::angle_t     ctl_val;

    assign rsp_data = out_reg;

    always_comb
    begin
        for (int i = 0; i < fdsc_pkg::NUM_DETENTS; i++)
        begin
            det[i] = cfg.detent[i];
        end
        d_lo     = det[0];
        d_hi     = det[fdsc_pkg::NUM_DETENTS-1];
        step_ext = {{(AW-fdsc_pkg::STEP_W){1'b0}}, cfg.step};

        // first detent at or above the request, then one back
        up_val = d_hi;
        for (int i = fdsc_pkg::NUM_DETENTS - 1; i > 0; i--)
        begin
            if (det[i] >= req_reg)
            begin
                up_val = det[i-1];
            end
        end
        if (det[0] >= req_reg)
        begin
            up_val = det[0];
        end

        dn_val = req_reg;
        for (int i = fdsc_pkg::NUM_DETENTS - 1; i >= 0; i--)
        begin
            if (det[i] > req_reg)
            begin
                dn_val = det[i];
            end
        end

        case (req_data.cmd)
            fdsc_pkg::CMD_UP:   new_req = up_val;
            fdsc_pkg::CMD_DOWN: new_req = dn_val;
            fdsc_pkg::CMD_SET:  new_req = req_data.angle;
            default:            new_req = req_reg;
        endcase

        diff = {target_reg[AW-1], target_reg} - {pos_reg[AW-1], pos_reg};
        mag  = diff[WW-1] ? WW'(-diff) : WW'(diff);

        req_next     = req_reg;
        target_next  = target_reg;
        pos_next     = pos_reg;
        slewing_next = slewing_reg;
        if (dp_cmd.accept)
        begin
            if (req_data.cmd == fdsc_pkg::CMD_TICK)
            begin
                if (slewing_reg)
                begin
                    if (mag > {{(WW-fdsc_pkg::STEP_W){1'b0}}, cfg.step})
                    begin
                        if (diff > 0)
                        begin
                            pos_next = pos_reg + step_ext;
                        end
                        else
                        begin
                            pos_next = pos_reg - step_ext;
                        end
                    end
                    else
                    begin
                        pos_next     = target_reg;
                        slewing_next = 1'b0;
                    end
                end
            end
            else
            begin
                req_next = new_req;
                if (new_req < d_lo)
                begin
                    target_next = d_lo;
                end
                else if (new_req > d_hi)
                begin
                    target_next = d_hi;
                end
                else
                begin
                    target_next = new_req;
                end
                slewing_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        pos_off  = {pos_reg[AW-1], pos_reg} - {d_lo[AW-1], d_lo};
        span     = {cfg.ctl_high[AW-1], cfg.ctl_high} - {cfg.ctl_low[AW-1], cfg.ctl_low};
        range_w  = {d_hi[AW-1], d_hi} - {d_lo[AW-1], d_lo};
        prod_w   = pos_off * span;
        rng_mag  = range_reg[WW-1] ? WW'(-range_reg) : WW'(range_reg);
        prod_mag = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);

        // one quotient bit a cycle, restoring
        trial = {rem_reg, quo_reg[DB-1]};
        q_bit = (trial >= {1'b0, dvs_reg});
        rem_w = q_bit ? AW'(trial - {1'b0, dvs_reg}) : trial[AW-1:0];

        q_signed = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        sum      = q_signed + SW'(cfg.ctl_low);
        if (zero_reg)
        begin
            ctl_val = cfg.ctl_low;
        end
        else if (sum > SW'(fdsc_pkg::ANGLE_MAX))
        begin
            ctl_val = fdsc_pkg::ANGLE_MAX;
        end
        else if (sum < SW'(fdsc_pkg::ANGLE_MIN))
        begin
            ctl_val = fdsc_pkg::ANGLE_MIN;
        end
        else
        begin
            ctl_val = sum[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg     <= '0;
            target_reg  <= '0;
            pos_reg     <= '0;
            slewing_reg <= 1'b0;
        end
        else
        begin
            req_reg     <= req_next;
            target_reg  <= target_next;
            pos_reg     <= pos_next;
            slewing_reg <= slewing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.mul)
        begin
            prod_reg  <= prod_w;
            range_reg <= range_w;
        end
        if (dp_cmd.load)
        begin
            neg_reg  <= prod_reg[PW-1] ^ range_reg[WW-1];
            zero_reg <= (range_reg == '0);
            dvs_reg  <= rng_mag[AW-1:0];
            quo_reg  <= prod_mag[DB-1:0];
            rem_reg  <= '0;
        end
        else if (dp_cmd.div)
        begin
            quo_reg <= {quo_reg[DB-2:0], q_bit};
            rem_reg <= rem_w;
        end
        if (dp_cmd.load_out)
        begin
            out_reg.target_angle  <= target_reg;
            out_reg.current_angle <= pos_reg;
            out_reg.control_value <= ctl_val;
            out_reg.moving        <= slewing_reg;
        end
    end

endmodule

// File: rtl/flap_detent_slew_controller_core.sv
// Flap detent slew controller. Each word taken on req (tick, step up, step down or set)
// either steps the slewed position (tick) or updates request and target, and yields one
// rsp word with target, current angle, moving flag and control value, which maps the
// current angle from the detent range onto ctl_low..ctl_high. The control value comes
// from a 17 by 17 bit multiply and a restoring divider that resolves one of 33 quotient
// bits per cycle; a word passes the multiply, load, divide and done states before its
// result is registered, and req_ready is high again from the cycle in which that result
// first shows on rsp; a result waiting on rsp does not hold up the next word until its
// own result is due. Angles are signed Q8.8 degrees; APB registers sit at byte address 4
// per index, written by the user only while the block is idle; the block never checks.
module flap_detent_slew_controller_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  fdsc_pkg::in_word_t           req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output fdsc_pkg::out_word_t          rsp_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [fdsc_pkg::DATA_W-1:0]  pwdata,
    output logic [fdsc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    fdsc_pkg::cfg_t    cfg;
    fdsc_pkg::dp_cmd_t dp_cmd;

    fdsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fdsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .dp_cmd    (dp_cmd)
    );

    fdsc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req_data (req_data),
        .dp_cmd   (dp_cmd),
        .rsp_data (rsp_data)
    );

endmodule

// File: rtl/fdsc_checker.sv
module fdsc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input fdsc_pkg::in_word_t  req_data,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input fdsc_pkg::out_word_t rsp_data
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("rsp word changed while stalled");

    // busy for the multiply and divide after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready ##1 !req_ready)
    else $error("req taken again during computation");

    // motion ends only on arrival
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.moving |-> rsp_data.current_angle == rsp_data.target_angle)
    else $error("stopped short of target");

endmodule

bind flap_detent_slew_controller_core fdsc_checker u_fdsc_checker (.*);
